### hdl/rrss_pkg.sv
// Shared types and codes for the round-robin slice scheduler.
package rrss_pkg;

    localparam int unsigned MAX_PROCESSES = 16;
    localparam int unsigned TIME_BITS     = 24;

    localparam int unsigned CMD_W      = 2;
    localparam int unsigned PNUM_W     = 5;
    localparam int unsigned FTIME_W    = TIME_BITS;
    localparam int unsigned CFG_DATA_W = TIME_BITS;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned COUNT_W    = 5;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 1'd1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [PNUM_W-1:0]  process_number;
        logic [FTIME_W-1:0] arrive_at;
        logic [FTIME_W-1:0] burst_len;
    } t_in;

    typedef struct packed {
        logic               slice_valid;
        logic [PNUM_W-1:0]  granted_process;
        logic [FTIME_W-1:0] granted_arrival;
        logic [FTIME_W-1:0] slice_length;
        logic               final_slice;
    } t_out;

endpackage

### hdl/rrss_ram.sv
// Simple dual-port memory with one write port and a registered read port.
module rrss_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/rrss_alu.sv
// Shared time comparator and subtractor used by both the sort and the slice step.
module rrss_alu #(
    parameter int unsigned WIDTH = 24
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic             o_lt,
    output logic             o_eq,
    output logic [WIDTH-1:0] o_diff
);

    logic [WIDTH:0] w_sub;

    // The borrow out of the subtraction gives the unsigned less-than.
    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_lt   = w_sub[WIDTH];
    assign o_eq   = (i_a == i_b);
    assign o_diff = w_sub[WIDTH-1:0];

endmodule

### hdl/round_robin_slice_scheduler.sv
// Round-robin time-slice scheduler: table, run queue and sequencer.
//
// Usage: requests arrive on the input channel (valid/ready) and carry a command.
// A load request writes one process entry into the table. A start request
// orders the first process_count entries by arrival time (ties to the lower
// process number) and fills the circular run queue with every entry whose
// burst is nonzero; the sort runs step by step, set by the single table read
// port and the one shared comparator, which ranks each entry against all others.
// A next-slice request pops the queue head, grants min(remaining, quantum)
// and re-queues any remainder; its result passes through the pop, read,
// calculate and emit states into the output register (pop and emit only when
// the schedule is exhausted), and no request is taken until it is placed there.
// Loads and starts give no result. The configuration port writes the quantum
// and the process count and must only be used while the block is idle.
// Reset empties the run queue and restores a quantum of 512 and a count of 1;
// the table keeps its contents. A stalled receiver holds the result in the
// output register; the block then takes further requests, but the result of a
// following next-slice request waits, with the block, until the held one is taken.
module round_robin_slice_scheduler
    import rrss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned PW = $clog2(MAX_PROCESSES);
    localparam int unsigned CW = $clog2(MAX_PROCESSES + 1);
    localparam int unsigned TB = TIME_BITS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SI   = 4'd1;
    localparam logic [3:0] ST_SIW  = 4'd2;
    localparam logic [3:0] ST_SJ   = 4'd3;
    localparam logic [3:0] ST_SW   = 4'd4;
    localparam logic [3:0] ST_POP  = 4'd5;
    localparam logic [3:0] ST_RD   = 4'd6;
    localparam logic [3:0] ST_CALC = 4'd7;
    localparam logic [3:0] ST_EMIT = 4'd8;

    logic [3:0]         r_state, n_state;
    logic [TB-1:0]      r_quantum;
    logic [COUNT_W-1:0] r_count;
    logic [PW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_fill, n_fill;
    logic [PW-1:0]      r_i, n_i;
    logic [PW-1:0]      r_j, n_j;
    logic [PW-1:0]      r_rank, n_rank;
    logic [TB-1:0]      r_ai, n_ai;
    logic [TB-1:0]      r_bi, n_bi;
    logic [PW-1:0]      r_p, n_p;
    t_out               r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_out               r_out_data, n_out_data;

    logic               w_accept;
    logic [CW-1:0]      w_n;
    logic [TB-1:0]      w_q;

    logic               w_tab_we;
    logic [PW-1:0]      w_tab_waddr;
    logic [PW-1:0]      w_tab_raddr;
    logic [2*TB-1:0]    w_tab_rdata;
    logic [TB-1:0]      w_arr_rd, w_bur_rd;

    logic               w_q_we;
    logic [PW-1:0]      w_q_waddr, w_q_wdata, w_q_rdata;
    logic               w_rem_we;
    logic [PW-1:0]      w_rem_waddr, w_rem_raddr;
    logic [TB-1:0]      w_rem_wdata, w_rem_rdata;

    logic [TB-1:0]      w_alu_a, w_alu_b, w_alu_diff;
    logic               w_alu_lt, w_alu_eq;
    logic               w_key_less;
    logic               w_gt;
    logic [CW:0]        w_tail_sum;
    logic [PW-1:0]      w_tail;
    logic [PW-1:0]      w_head_inc;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_n = (32'(r_count) > MAX_PROCESSES) ? CW'(MAX_PROCESSES) : CW'(r_count);
    assign w_q = (r_quantum == '0) ? TB'(1) : r_quantum;

    // Table of {arrival, burst}, written by load requests only.
    assign w_tab_we    = w_accept && (i_in_data.command == CMD_LOAD)
                      && (i_in_data.process_number != '0)
                      && (32'(i_in_data.process_number) <= MAX_PROCESSES);
    assign w_tab_waddr = PW'(32'(i_in_data.process_number) - 32'd1);

    always_comb begin
        unique case (r_state)
            ST_SIW:  w_tab_raddr = '0;
            ST_SJ:   w_tab_raddr = PW'(32'(r_j) + 32'd1);
            ST_RD:   w_tab_raddr = w_q_rdata;
            ST_CALC: w_tab_raddr = r_p;
            default: w_tab_raddr = r_i;
        endcase
    end

    rrss_ram #(.DEPTH(MAX_PROCESSES), .WIDTH(2 * TB)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (w_tab_waddr),
        .i_wdata ({TB'(i_in_data.arrive_at), TB'(i_in_data.burst_len)}),
        .i_raddr (w_tab_raddr),
        .o_rdata (w_tab_rdata)
    );

    assign w_arr_rd = w_tab_rdata[2*TB-1:TB];
    assign w_bur_rd = w_tab_rdata[TB-1:0];

    rrss_ram #(.DEPTH(MAX_PROCESSES), .WIDTH(PW)) u_queue (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (w_q_wdata),
        .i_raddr (r_head),
        .o_rdata (w_q_rdata)
    );

    assign w_rem_raddr = (r_state == ST_RD) ? w_q_rdata : r_p;

    rrss_ram #(.DEPTH(MAX_PROCESSES), .WIDTH(TB)) u_remain (
        .i_clk   (i_clk),
        .i_we    (w_rem_we),
        .i_waddr (w_rem_waddr),
        .i_wdata (w_rem_wdata),
        .i_raddr (w_rem_raddr),
        .o_rdata (w_rem_rdata)
    );

    // The sort compares arrival times; the slice step compares remaining against quantum.
    assign w_alu_a = (r_state == ST_SJ) ? w_arr_rd : w_rem_rdata;
    assign w_alu_b = (r_state == ST_SJ) ? r_ai : w_q;

    rrss_alu #(.WIDTH(TB)) u_alu (
        .i_a    (w_alu_a),
        .i_b    (w_alu_b),
        .o_lt   (w_alu_lt),
        .o_eq   (w_alu_eq),
        .o_diff (w_alu_diff)
    );

    assign w_key_less = w_alu_lt || (w_alu_eq && (r_j < r_i));
    assign w_gt       = !w_alu_lt && !w_alu_eq;

    // Tail slot after the pop equals the old head plus the old fill.
    assign w_tail_sum = (CW + 1)'(r_head) + (CW + 1)'(r_fill);
    assign w_tail     = (32'(w_tail_sum) >= MAX_PROCESSES)
                      ? PW'(32'(w_tail_sum) - MAX_PROCESSES) : PW'(w_tail_sum);
    assign w_head_inc = (32'(r_head) + 32'd1 >= MAX_PROCESSES) ? '0 : PW'(32'(r_head) + 32'd1);

    always_comb begin
        w_q_we      = 1'b0;
        w_q_waddr   = w_tail;
        w_q_wdata   = r_p;
        w_rem_we    = 1'b0;
        w_rem_waddr = r_p;
        w_rem_wdata = w_alu_diff;
        if (r_state == ST_SW) begin
            w_q_we      = (r_bi != '0);
            w_q_waddr   = r_rank;
            w_q_wdata   = r_i;
            w_rem_we    = (r_bi != '0);
            w_rem_waddr = r_i;
            w_rem_wdata = r_bi;
        end else if (r_state == ST_CALC) begin
            w_q_we      = w_gt;
            w_rem_we    = 1'b1;
            w_rem_wdata = w_gt ? w_alu_diff : '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_i         = r_i;
        n_j         = r_j;
        n_rank      = r_rank;
        n_ai        = r_ai;
        n_bi        = r_bi;
        n_p         = r_p;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_data.command)
                        CMD_START: begin
                            n_head = '0;
                            n_fill = '0;
                            n_i    = '0;
                            if (w_n != '0) begin
                                n_state = ST_SI;
                            end
                        end
                        CMD_NEXT: n_state = ST_POP;
                        default: ;
                    endcase
                end
            end
            ST_SI: n_state = ST_SIW;
            ST_SIW: begin
                n_ai    = w_arr_rd;
                n_bi    = w_bur_rd;
                n_j     = '0;
                n_rank  = '0;
                n_state = ST_SJ;
            end
            ST_SJ: begin
                if ((w_bur_rd != '0) && w_key_less) begin
                    n_rank = r_rank + PW'(1);
                end
                if (32'(r_j) + 32'd1 == 32'(w_n)) begin
                    n_state = ST_SW;
                end else begin
                    n_j = r_j + PW'(1);
                end
            end
            ST_SW: begin
                if (r_bi != '0) begin
                    n_fill = r_fill + CW'(1);
                end
                if (32'(r_i) + 32'd1 == 32'(w_n)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_i     = r_i + PW'(1);
                    n_state = ST_SI;
                end
            end
            ST_POP: begin
                if (r_fill == '0) begin
                    n_res   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_p     = w_q_rdata;
                n_state = ST_CALC;
            end
            ST_CALC: begin
                n_head                = w_head_inc;
                n_fill                = w_gt ? r_fill : r_fill - CW'(1);
                n_res.slice_valid     = 1'b1;
                n_res.granted_process = PNUM_W'(32'(r_p) + 32'd1);
                n_res.granted_arrival = FTIME_W'(w_arr_rd);
                n_res.slice_length    = FTIME_W'(w_gt ? w_q : w_rem_rdata);
                n_res.final_slice     = !w_gt;
                n_state               = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_quantum   <= TB'(512);
            r_count     <= COUNT_W'(1);
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_QUANTUM: r_quantum <= TB'(i_cfg_data);
                    CFG_COUNT:   r_count   <= COUNT_W'(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_rank     <= n_rank;
        r_ai       <= n_ai;
        r_bi       <= n_bi;
        r_p        <= n_p;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### hdl/rrss_chk.sv
// Port-level checks for the round-robin slice scheduler, bound to the top level.
module rrss_chk
    import rrss_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // A result waiting on a stalled receiver must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or vanished while stalled");

    // An exhausted schedule reports all fields as zero.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.slice_valid |->
            o_out_data.granted_process == '0 && o_out_data.granted_arrival == '0 &&
            o_out_data.slice_length == '0 && !o_out_data.final_slice)
        else $error("exhausted result carries nonzero fields");

    // Only nonzero bursts are queued, so every granted slice has some length.
    a_slice_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.slice_valid |-> o_out_data.slice_length != '0)
        else $error("granted slice of zero length");

    // A next-slice request keeps the block busy for at least the following cycle.
    a_next_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.command == CMD_NEXT |=> !o_in_ready)
        else $error("ready straight after a next-slice request");

endmodule

bind round_robin_slice_scheduler rrss_chk u_rrss_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### sim/testbench.sv
// Self-checking testbench for the round-robin slice scheduler.
`timescale 1ns / 1ps

module testbench;
    import rrss_pkg::*;

    localparam int unsigned N_PROC        = 16;
    localparam int unsigned CLK_PERIOD    = 10;
    localparam int unsigned SETTLE_CYCLES = 400;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned LIMIT_CYCLES  = 4_000_000;
    localparam int unsigned RANDOM_ITEMS  = 800;
    localparam int unsigned STEADY_ITEMS  = 250;
    localparam logic [FTIME_W-1:0] TIME_MAX = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Mirror of the scheduler state.
    logic [FTIME_W-1:0] tbl_arrival [N_PROC];
    logic [FTIME_W-1:0] tbl_burst   [N_PROC];
    logic [FTIME_W-1:0] left_burst  [N_PROC];
    logic [3:0]         run_ring    [N_PROC];
    logic [3:0]         ring_head;
    logic [4:0]         ring_fill;
    logic [FTIME_W-1:0] quantum_reg;
    logic [COUNT_W-1:0] count_reg;

    t_out pending_slices [$];
    int   errors;
    int   counted_items;
    bit   tx_idle_on;
    bit   rx_idle_on;
    bit   hold_output;

    round_robin_slice_scheduler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("round_robin_slice_scheduler regression: fail");
        $finish;
    end

    function automatic logic [FTIME_W-1:0] effective_quantum();
        return (quantum_reg == '0) ? FTIME_W'(1) : quantum_reg;
    endfunction

    // Orders the taking-part entries by arrival, lower process number first on a tie,
    // and queues those with burst left.
    function automatic void build_run_queue();
        int unsigned order [N_PROC];
        int unsigned n;
        int unsigned i;
        int unsigned j;
        int unsigned tmp;
        n = (count_reg > N_PROC) ? N_PROC : count_reg;
        for (i = 0; i < N_PROC; i++) begin
            order[i] = i;
            left_burst[i] = '0;
        end
        for (i = 1; i < n; i++) begin
            for (j = i; j > 0 && tbl_arrival[order[j-1]] > tbl_arrival[order[j]]; j--) begin
                tmp = order[j];
                order[j] = order[j-1];
                order[j-1] = tmp;
            end
        end
        ring_head = '0;
        ring_fill = '0;
        for (i = 0; i < n; i++) begin
            if (tbl_burst[order[i]] != '0) begin
                left_burst[order[i]] = tbl_burst[order[i]];
                run_ring[ring_fill[3:0]] = 4'(order[i]);
                ring_fill = ring_fill + 5'd1;
            end
        end
    endfunction

    function automatic t_out grant_slice();
        t_out               s;
        logic [3:0]         p;
        logic [FTIME_W-1:0] q;
        logic [FTIME_W-1:0] r;
        s = '0;
        q = effective_quantum();
        if (ring_fill == '0)
            return s;
        p = run_ring[ring_head];
        ring_head = ring_head + 4'd1;
        ring_fill = ring_fill - 5'd1;
        r = left_burst[p];
        s.slice_valid     = 1'b1;
        s.granted_process = PNUM_W'(p) + PNUM_W'(1);
        s.granted_arrival = tbl_arrival[p];
        if (r > q) begin
            s.slice_length = q;
            left_burst[p] = r - q;
            run_ring[ring_head + ring_fill[3:0]] = p;
            ring_fill = ring_fill + 5'd1;
        end else begin
            s.slice_length = r;
            s.final_slice  = 1'b1;
            left_burst[p] = '0;
        end
        return s;
    endfunction

    function automatic logic [FTIME_W-1:0] pick_arrival();
        case ($urandom_range(0, 3))
            0: return FTIME_W'($urandom_range(0, 3) << 8);
            1: return FTIME_W'($urandom);
            2: return $urandom_range(0, 1) ? TIME_MAX : '0;
            default: return FTIME_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Bursts mostly lie within five quanta; some are zero or the maximum time.
    function automatic logic [FTIME_W-1:0] pick_burst();
        longint unsigned q;
        longint unsigned v;
        q = effective_quantum();
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = q * $urandom_range(1, 3);
            2: v = TIME_MAX;
            default: v = $urandom_range(1, 32'((q * 5 > TIME_MAX) ? TIME_MAX : q * 5));
        endcase
        return (v > TIME_MAX) ? TIME_MAX : FTIME_W'(v);
    endfunction

    function automatic logic [FTIME_W-1:0] pick_quantum();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return FTIME_W'(1);
            2: return TIME_MAX;
            3: return FTIME_W'($urandom);
            default: return FTIME_W'($urandom_range(16, 2048));
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COUNT_W'($urandom_range(17, 31));
            2: return COUNT_W'(N_PROC);
            default: return COUNT_W'($urandom_range(1, N_PROC));
        endcase
    endfunction

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [PNUM_W-1:0] pnum,
                                input logic [FTIME_W-1:0] arrival,
                                input logic [FTIME_W-1:0] burst);
        t_in req;
        req.command        = cmd;
        req.process_number = pnum;
        req.arrive_at      = arrival;
        req.burst_len      = burst;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        case (cmd)
            CMD_LOAD: begin
                if (pnum >= 1 && pnum <= N_PROC) begin
                    tbl_arrival[pnum - 1] = arrival;
                    tbl_burst[pnum - 1]   = burst;
                    counted_items++;
                end
            end
            CMD_START: begin
                build_run_queue();
                counted_items++;
            end
            CMD_NEXT: begin
                pending_slices.push_back(grant_slice());
                counted_items++;
            end
            default: ;
        endcase
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 1))
            send_request(CMD_NONE, PNUM_W'($urandom), FTIME_W'($urandom), FTIME_W'($urandom));
        else
            send_request(CMD_LOAD, $urandom_range(0, 1) ? PNUM_W'(0) :
                         PNUM_W'($urandom_range(17, 31)), FTIME_W'($urandom),
                         FTIME_W'($urandom));
    endtask

    task automatic send_next();
        send_request(CMD_NEXT, PNUM_W'($urandom), FTIME_W'($urandom), FTIME_W'($urandom));
    endtask

    task automatic send_start();
        send_request(CMD_START, PNUM_W'($urandom), FTIME_W'($urandom), FTIME_W'($urandom));
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_slices.size() != 0);
    endtask

    // A start request gives no result, so the sort may still be running after the
    // last slice has come back; give it time before touching the registers.
    task automatic quiesce();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_registers(input logic [FTIME_W-1:0] quantum,
                                   input logic [COUNT_W-1:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_QUANTUM;
        i_cfg_data  <= CFG_DATA_W'(quantum);
        @(posedge i_clk);
        i_cfg_index <= CFG_COUNT;
        i_cfg_data  <= CFG_DATA_W'(count);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        quantum_reg = quantum;
        count_reg   = count;
    endtask

    // Requests slices until the queue runs dry or the cap is reached, with the odd
    // table load or ignored request mixed in. The quantum may change part way through.
    task automatic drain_schedule(input int cap, input int change_at);
        int k;
        k = 0;
        while (ring_fill != '0 && k < cap) begin
            if (k == change_at) begin
                quiesce();
                write_registers(pick_quantum(), count_reg);
            end
            case ($urandom_range(0, 11))
                0: send_request(CMD_LOAD, PNUM_W'($urandom_range(1, N_PROC)),
                                pick_arrival(), pick_burst());
                1: send_noise();
                default: ;
            endcase
            send_next();
            k++;
        end
        send_next();
    endtask

    task automatic test_directed_cases();
        int                 pn;
        logic [FTIME_W-1:0] arrival;
        logic [FTIME_W-1:0] burst;
        // Nothing scheduled yet, so the slice request reports an exhausted schedule.
        send_next();
        for (pn = 1; pn <= N_PROC; pn++) begin
            arrival = (pn == 1) ? TIME_MAX : FTIME_W'((pn % 4) << 8);
            burst   = (pn == 5) ? '0 : (pn == 2) ? TIME_MAX : FTIME_W'(pn * 'h80);
            send_request(CMD_LOAD, PNUM_W'(pn), arrival, burst);
        end
        send_request(CMD_LOAD, PNUM_W'(0), TIME_MAX, TIME_MAX);
        send_request(CMD_LOAD, PNUM_W'(17), TIME_MAX, TIME_MAX);
        send_request(CMD_LOAD, PNUM_W'(31), '0, TIME_MAX);
        send_request(CMD_NONE, PNUM_W'(31), TIME_MAX, TIME_MAX);
        send_start();
        send_next();
        send_next();
    endtask

    task automatic test_register_extremes();
        logic [FTIME_W-1:0] quanta [5] = '{24'hFFFFFF, 24'h0, 24'h1, 24'h200, 24'h80};
        logic [COUNT_W-1:0] counts [5] = '{5'd16, 5'd16, 5'd0, 5'd31, 5'd16};
        int i;
        for (i = 0; i < 5; i++) begin
            quiesce();
            write_registers(quanta[i], counts[i]);
            send_start();
            drain_schedule(48, -1);
        end
    endtask

    // The receiver stops for a long stretch while slice requests keep coming, so the
    // held result blocks the next slice request and the input stalls.
    task automatic test_output_backpressure();
        int i;
        quiesce();
        write_registers(FTIME_W'('h100), COUNT_W'(N_PROC));
        for (i = 1; i <= 8; i++)
            send_request(CMD_LOAD, PNUM_W'(i), pick_arrival(), FTIME_W'('h400));
        hold_output = 1'b1;
        send_start();
        for (i = 0; i < 30; i++)
            send_next();
    endtask

    task automatic test_sender_pause();
        int i;
        for (i = 0; i < 3; i++)
            send_next();
        pause_until_drained();
        for (i = 0; i < 3; i++)
            send_next();
    endtask

    task automatic run_random_schedule();
        int loads;
        int cap;
        int k;
        if ($urandom_range(0, 2) == 0) begin
            quiesce();
            write_registers(pick_quantum(), pick_count());
        end
        loads = $urandom_range(0, N_PROC);
        for (k = 0; k < loads; k++) begin
            if ($urandom_range(0, 7) == 0)
                send_noise();
            send_request(CMD_LOAD, PNUM_W'($urandom_range(1, N_PROC)), pick_arrival(),
                         pick_burst());
        end
        send_start();
        cap = $urandom_range(4, 60);
        drain_schedule(cap, ($urandom_range(0, 5) == 0) ? $urandom_range(1, cap) : -1);
    endtask

    task automatic test_random_schedules();
        int stop_at;
        stop_at = counted_items + RANDOM_ITEMS;
        while (counted_items < stop_at)
            run_random_schedule();
    endtask

    task automatic test_steady_stream();
        int stop_at;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        stop_at = counted_items + STEADY_ITEMS;
        while (counted_items < stop_at)
            run_random_schedule();
    endtask

    // Receiver: random short stalls, plus one long hold when a test asks for it.
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_output) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_slices.size() == 0) begin
                $error("slice result with no request outstanding: %p", o_out_data);
                errors++;
            end else begin
                want = pending_slices.pop_front();
                if (o_out_data.slice_valid !== want.slice_valid) begin
                    $error("slice_valid: expected %0d, got %0d",
                           want.slice_valid, o_out_data.slice_valid);
                    errors++;
                end
                if (o_out_data.granted_process !== want.granted_process) begin
                    $error("granted_process: expected %0d, got %0d",
                           want.granted_process, o_out_data.granted_process);
                    errors++;
                end
                if (o_out_data.granted_arrival !== want.granted_arrival) begin
                    $error("granted_arrival: expected %h, got %h",
                           want.granted_arrival, o_out_data.granted_arrival);
                    errors++;
                end
                if (o_out_data.slice_length !== want.slice_length) begin
                    $error("slice_length: expected %h, got %h",
                           want.slice_length, o_out_data.slice_length);
                    errors++;
                end
                if (o_out_data.final_slice !== want.final_slice) begin
                    $error("final_slice: expected %0d, got %0d",
                           want.final_slice, o_out_data.final_slice);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors        = 0;
        counted_items = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_output   = 1'b0;
        quantum_reg   = FTIME_W'('h200);
        count_reg     = COUNT_W'(1);
        ring_head     = '0;
        ring_fill     = '0;
        for (int i = 0; i < N_PROC; i++) begin
            tbl_arrival[i] = '0;
            tbl_burst[i]   = '0;
            left_burst[i]  = '0;
            run_ring[i]    = '0;
        end
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_QUANTUM;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_register_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_random_schedules();
        test_steady_stream();

        i_in_valid <= 1'b0;
        while (pending_slices.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("round_robin_slice_scheduler regression: pass");
        else
            $display("round_robin_slice_scheduler regression: fail");
        $finish;
    end

endmodule

### filelist.f
hdl/rrss_pkg.sv
hdl/rrss_ram.sv
hdl/rrss_alu.sv
hdl/round_robin_slice_scheduler.sv
hdl/rrss_chk.sv
sim/testbench.sv
